>>> sv/atcr_pkg.sv
// Shared types, codes and pattern constants for the AT command recogniser.
package atcr_pkg;

   // Default line buffer size; a body after A and T may hold up to BUF_SIZE-3 bytes
   localparam int unsigned BufSizeDefault = 64;

   // Characters of interest
   localparam logic [7:0] ChrUpperA = 8'h41;
   localparam logic [7:0] ChrLowerA = 8'h61;
   localparam logic [7:0] ChrUpperT = 8'h54;
   localparam logic [7:0] ChrLowerT = 8'h74;
   localparam logic [7:0] ChrCr     = 8'h0D;
   localparam logic [7:0] ChrLf     = 8'h0A;
   localparam logic [7:0] ChrNul    = 8'h00;

   // Length of the searched string "AT+TEST"
   localparam int unsigned PatternLen = 7;

   // Line phase
   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_WAIT_T = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   // Response codes
   typedef enum logic [1:0] {
      RESP_OK    = 2'd0,
      RESP_TEST  = 2'd1,
      RESP_ERROR = 2'd2
   } resp_type;

   // Outcome of one byte step
   typedef struct packed {
      logic     valid;
      resp_type code;
   } step_result_type;

   // Character of "AT+TEST" at a given position
   function automatic logic [7:0] pattern_char(input logic [2:0] idx);
      logic [7:0] chr;
      unique case (idx)
         3'd0:    chr = 8'h41; // A
         3'd1:    chr = 8'h54; // T
         3'd2:    chr = 8'h2B; // +
         3'd3:    chr = 8'h54; // T
         3'd4:    chr = 8'h45; // E
         3'd5:    chr = 8'h53; // S
         3'd6:    chr = 8'h54; // T
         default: chr = 8'h00;
      endcase
      return chr;
   endfunction

endpackage

>>> sv/atcr_line_tracker.sv
// Line state machine and streaming "AT+TEST" matcher, one byte per step.
module atcr_line_tracker import atcr_pkg::*; #(
   parameter int unsigned BUF_SIZE = BufSizeDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  logic [7:0]      step_byte,
   output step_result_type step_result
);

   localparam int unsigned LenW = $clog2(BUF_SIZE);
   localparam logic [LenW-1:0] LenLimit = LenW'(BUF_SIZE - 1);

   phase_type      phase_ff, phase_in;
   logic [LenW-1:0] len_ff, len_in;
   logic           upper_ff, upper_in;
   logic [2:0]     prog_ff, prog_in;
   logic           found_ff, found_in;
   logic           zero_ff, zero_in;

   // matcher outputs for the current byte
   logic [2:0]     m_prog;
   logic           m_found;
   logic           m_zero;

   // Advance the matcher over the current byte
   always_comb begin
      m_prog  = prog_ff;
      m_found = found_ff;
      m_zero  = zero_ff;
      if (!zero_ff && !found_ff) begin
         if (step_byte == ChrNul) begin
            m_zero = 1'b1;
         end else if (step_byte == pattern_char(prog_ff)) begin
            if (prog_ff == 3'(PatternLen - 1)) begin
               m_found = 1'b1;
               m_prog  = 3'd0;
            end else begin
               m_prog = prog_ff + 3'd1;
            end
         end else begin
            m_prog = (step_byte == ChrUpperA) ? 3'd1 : 3'd0;
         end
      end
   end

   // Next line state and response
   always_comb begin
      phase_in    = phase_ff;
      len_in      = len_ff;
      upper_in    = upper_ff;
      prog_in     = prog_ff;
      found_in    = found_ff;
      zero_in     = zero_ff;
      step_result = '{valid: 1'b0, code: RESP_ERROR};

      if (step_en) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (step_byte == ChrUpperA || step_byte == ChrLowerA) begin
                  phase_in = PH_WAIT_T;
                  len_in   = LenW'(1);
                  upper_in = (step_byte == ChrUpperA);
                  prog_in  = m_prog;
                  found_in = m_found;
                  zero_in  = m_zero;
               end
            end
            PH_WAIT_T: begin
               if (step_byte == ChrUpperT || step_byte == ChrLowerT) begin
                  phase_in = PH_BODY;
                  len_in   = LenW'(2);
                  upper_in = upper_ff && (step_byte == ChrUpperT);
                  prog_in  = m_prog;
                  found_in = m_found;
                  zero_in  = m_zero;
               end else begin
                  phase_in = PH_IDLE;
                  len_in   = '0;
                  upper_in = 1'b0;
                  prog_in  = '0;
                  found_in = 1'b0;
                  zero_in  = 1'b0;
               end
            end
            PH_BODY: begin
               if (step_byte == ChrCr || step_byte == ChrLf) begin
                  // terminator: answer and drop the line
                  step_result.valid = 1'b1;
                  if (step_byte == ChrCr && upper_ff && len_ff == LenW'(2)) begin
                     step_result.code = RESP_OK;
                  end else if (found_ff) begin
                     step_result.code = RESP_TEST;
                  end else begin
                     step_result.code = RESP_ERROR;
                  end
                  phase_in = PH_IDLE;
                  len_in   = '0;
                  upper_in = 1'b0;
                  prog_in  = '0;
                  found_in = 1'b0;
                  zero_in  = 1'b0;
               end else if (len_ff < LenLimit) begin
                  len_in   = len_ff + LenW'(1);
                  prog_in  = m_prog;
                  found_in = m_found;
                  zero_in  = m_zero;
               end else begin
                  // body full: drop the line silently
                  phase_in = PH_IDLE;
                  len_in   = '0;
                  upper_in = 1'b0;
                  prog_in  = '0;
                  found_in = 1'b0;
                  zero_in  = 1'b0;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               len_in   = '0;
               upper_in = 1'b0;
               prog_in  = '0;
               found_in = 1'b0;
               zero_in  = 1'b0;
            end
         endcase
      end
   end

   // Hold line state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         len_ff   <= '0;
         upper_ff <= 1'b0;
         prog_ff  <= '0;
         found_ff <= 1'b0;
         zero_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         upper_ff <= upper_in;
         prog_ff  <= prog_in;
         found_ff <= found_in;
         zero_ff  <= zero_in;
      end
   end

endmodule

>>> sv/at_command_recognizer_top.sv
// Top level of the AT command recogniser: input register, line tracker, result register.
//
// Usage:
//   The req_ channel carries received serial bytes (req_rx_byte), one per transfer.
//   A line starts with A or a followed by T or t; any other second byte drops it.
//   Body bytes are collected until CR or LF, and the terminator produces exactly
//   one transfer on the rsp_ channel with rsp_response: 0 OK (uppercase "AT" then
//   CR), 1 when "AT+TEST" occurred before any zero byte, 2 ERROR otherwise.
//   Bytes that start no line, or a body exceeding BUF_SIZE-3 bytes, give nothing.
// Timing:
//   An accepted byte waits in the input register until the result register is free;
//   the tracker then steps it, and any response loads the result register and rsp_valid.
//   Throughput is one byte per cycle unless a response waits; the line tracker sets it.
// Reset and stalls:
//   Reset empties both registers and returns the tracker to idle.
//   While a response waits for rsp_ready, the byte in the input register holds,
//   and req_ready falls once that register is also full; no byte is lost.
module at_command_recognizer_top import atcr_pkg::*; #(
   parameter int unsigned BUF_SIZE = BufSizeDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_response
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            out_valid_ff, out_valid_in;
   resp_type        out_code_ff;
   logic            step_en;
   step_result_type step_result;

   // Process the held byte whenever the result register can take a result
   assign step_en   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_en;

   atcr_line_tracker #(
      .BUF_SIZE(BUF_SIZE)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .step_byte  (in_byte_ff),
      .step_result(step_result)
   );

   // Next valid flags of both registers
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (step_en) begin
         out_valid_in = step_result.valid;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Hold control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (step_en && step_result.valid) begin
         out_code_ff <= step_result.code;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_response = out_code_ff;

endmodule

>>> test/at_command_recognizer_checker.sv
// Checker for the AT command recogniser: tracks lines per byte and compares responses.
module at_command_recognizer_checker import atcr_pkg::*; #(
   parameter int unsigned BUF_SIZE = BufSizeDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [1:0] rsp_response,
   output int         fail_count,
   output int         pending_results
);

   localparam logic [55:0] TestStr = "AT+TEST";

   // Line tracker state
   phase_type  line_phase;
   logic [8:0] line_len;
   bit         upper_prefix;
   logic [2:0] match_pos;
   bit         test_seen;
   bit         nul_seen;

   resp_type   expected_responses[$];

   function automatic void clear_line();
      line_phase   = PH_IDLE;
      line_len     = '0;
      upper_prefix = 1'b0;
      match_pos    = '0;
      test_seen    = 1'b0;
      nul_seen     = 1'b0;
   endfunction

   // Stream one character through the "AT+TEST" search; stop at the first zero byte
   function automatic void advance_test_match(input logic [7:0] chr);
      logic [2:0] pos;
      pos = match_pos;
      if (nul_seen || test_seen) return;
      if (chr == ChrNul) begin
         nul_seen = 1'b1;
         return;
      end
      if (pos >= PatternLen) pos = '0;
      if (chr == TestStr[8 * (PatternLen - 1 - pos) +: 8]) begin
         if (pos == PatternLen - 1) begin
            test_seen = 1'b1;
            pos       = '0;
         end else begin
            pos = pos + 3'd1;
         end
      end else begin
         pos = (chr == ChrUpperA) ? 3'd1 : 3'd0;
      end
      match_pos = pos;
   endfunction

   // Advance the line tracker by one byte; a terminator in the body yields a response
   function automatic void predict_response(input logic [7:0] chr, output bit answered,
                                            output resp_type code);
      answered = 1'b0;
      code     = RESP_ERROR;
      case (line_phase)
         PH_IDLE: begin
            if (chr == ChrUpperA || chr == ChrLowerA) begin
               line_len     = 9'd1;
               upper_prefix = (chr == ChrUpperA);
               advance_test_match(chr);
               line_phase   = PH_WAIT_T;
            end
         end
         PH_WAIT_T: begin
            if (chr == ChrUpperT || chr == ChrLowerT) begin
               upper_prefix = upper_prefix && (chr == ChrUpperT);
               advance_test_match(chr);
               line_len     = 9'd2;
               line_phase   = PH_BODY;
            end else begin
               clear_line();
            end
         end
         PH_BODY: begin
            if (chr == ChrCr || chr == ChrLf) begin
               answered = 1'b1;
               if (chr == ChrCr && upper_prefix && line_len == 9'd2) code = RESP_OK;
               else if (test_seen) code = RESP_TEST;
               else code = RESP_ERROR;
               clear_line();
            end else if (line_len < BUF_SIZE - 1) begin
               advance_test_match(chr);
               line_len = line_len + 9'd1;
            end else begin
               // body overflow: drop the line silently
               clear_line();
            end
         end
         default: clear_line();
      endcase
   endfunction

   // Compare each response transfer, then predict from each byte transfer
   always @(posedge clock) begin : watch_channels
      resp_type want;
      resp_type code;
      bit       answered;
      if (reset) begin
         clear_line();
         expected_responses.delete();
         pending_results = 0;
      end else begin
         if ($isunknown(rsp_valid)) begin
            $error("rsp_valid: expected 0 or 1, actual %b", rsp_valid);
            fail_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               $error("rsp_response: expected none, actual %0d", rsp_response);
               fail_count++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_response !== want) begin
                  $error("rsp_response: expected %0d, actual %0d", want, rsp_response);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_response(req_rx_byte, answered, code);
            if (answered) expected_responses.push_back(code);
         end
         pending_results = expected_responses.size();
      end
   end

endmodule

>>> test/tb.sv
// Testbench top for the AT command recogniser: clock, reset, byte stimulus and verdict.
module tb;
   import atcr_pkg::*;

   localparam int unsigned BufSize    = BufSizeDefault;
   localparam int          ItemTarget = 1750;
   localparam int          CycleLimit = 400000;
   localparam int          HoldCycles = 200;
   localparam logic [55:0] TestStr    = "AT+TEST";

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [1:0] rsp_response;

   int fail_count;
   int pending_results;
   int items_sent;
   int cycle_count;
   int send_idle_pct;
   int recv_idle_pct;
   bit hold_request;

   at_command_recognizer_top #(.BUF_SIZE(BufSize)) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_response (rsp_response)
   );

   at_command_recognizer_checker #(.BUF_SIZE(BufSize)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_response    (rsp_response),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // End the run if it stalls
   initial begin : watchdog
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("at_command_recognizer_top: mismatch");
      $finish;
   end

   // Drive rsp_ready: random stalls, or one long hold-off on request
   initial begin : response_sink
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HoldCycles - 1) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
         end
      end
   end

   // Offer one byte after an optional gap and hold it until the transfer
   task automatic send_byte(input logic [7:0] value, input bit counted);
      @(negedge clock);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (counted) items_sent++;
   endtask

   task automatic send_text_line(input string text, input logic [7:0] term);
      for (int i = 0; i < text.len(); i++) send_byte(text[i], 1'b1);
      send_byte(term, 1'b1);
   endtask

   // Hold the sender until every expected response has arrived
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_results == 0);
   endtask

   // One random line: mostly well-formed with random body, some noise and broken prefixes
   task automatic send_random_line();
      logic [7:0] body[$];
      logic [7:0] chr;
      logic [7:0] term;
      int         len;
      int         roll;
      int         pos;
      roll = $urandom_range(99, 0);
      if (roll < 8) begin
         repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255, 0)), 1'b0);
      end else if (roll < 16) begin
         send_byte(($urandom_range(1, 0) != 0) ? ChrUpperA : ChrLowerA, 1'b1);
         send_byte(8'($urandom_range(255, 0)), 1'b1);
      end else begin
         roll = $urandom_range(99, 0);
         if (roll < 70) len = $urandom_range(8, 0);
         else if (roll < 90) len = $urandom_range(40, 9);
         else len = $urandom_range(BufSize, BufSize - 4);
         for (int i = 0; i < len; i++) begin
            roll = $urandom_range(99, 0);
            if (roll < 30) chr = TestStr[8 * $urandom_range(6, 0) +: 8];
            else if (roll < 34) chr = ChrNul;
            else if (roll < 40) chr = 8'($urandom_range(255, 0));
            else chr = 8'($urandom_range(8'h7E, 8'h20));
            body.push_back(chr);
         end
         // plant the whole pattern, or its tail so that the prefix completes it
         if (len >= 7 && $urandom_range(99, 0) < 30) begin
            pos = $urandom_range(len - 7, 0);
            for (int k = 0; k < 7; k++) body[pos + k] = TestStr[8 * (6 - k) +: 8];
         end else if (len >= 5 && $urandom_range(99, 0) < 15) begin
            for (int k = 0; k < 5; k++) body[k] = TestStr[8 * (4 - k) +: 8];
         end
         term = ($urandom_range(99, 0) < 60) ? ChrCr : ChrLf;
         send_byte(($urandom_range(99, 0) < 75) ? ChrUpperA : ChrLowerA, 1'b1);
         send_byte(($urandom_range(99, 0) < 75) ? ChrUpperT : ChrLowerT, 1'b1);
         foreach (body[i]) send_byte(body[i], 1'b1);
         send_byte(term, 1'b1);
      end
   endtask

   initial begin : stimulus
      send_idle_pct = 6;
      recv_idle_pct = 55;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle bytes that start nothing, then a prefix dropped by its second byte
      send_byte(8'hFF, 1'b0);
      send_byte(ChrNul, 1'b0);
      send_byte(ChrUpperA, 1'b1);
      send_byte("X", 1'b1);
      send_text_line("AT", ChrCr);
      send_text_line("aT", ChrLf);
      send_text_line("AT+TEST", ChrCr);
      // zero byte in the body
      send_byte(ChrUpperA, 1'b1);
      send_byte(ChrUpperT, 1'b1);
      send_byte(ChrNul, 1'b1);
      send_byte(ChrCr, 1'b1);
      wait_for_drain();

      // long receiver hold-off while short lines keep coming
      hold_request = 1'b1;
      repeat (12) send_text_line("AT", ChrCr);
      wait_for_drain();

      while (items_sent < ItemTarget / 3) send_random_line();
      wait_for_drain();

      send_idle_pct = 55;
      recv_idle_pct = 6;
      while (items_sent < 2 * ItemTarget / 3) send_random_line();
      wait_for_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (items_sent < ItemTarget) send_random_line();

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_results == 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("at_command_recognizer_top: match");
      end else begin
         $display("at_command_recognizer_top: mismatch");
      end
      $finish;
   end

endmodule

>>> files.f
sv/atcr_pkg.sv
sv/atcr_line_tracker.sv
sv/at_command_recognizer_top.sv
test/at_command_recognizer_checker.sv
test/tb.sv
